FILE: design/msie_pkg.sv
// Package for the single-issue instruction execute block.
// Holds sizing constants, opcode and function codes, and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package msie_pkg;

    localparam int PC_BITS   = 16;
    localparam int RAM_WORDS = 1024;
    localparam int RAM_AW    = $clog2(RAM_WORDS);
    localparam int OUT_PC_W  = 16;
    localparam int LEN_W     = 16;
    localparam int WORD_W    = 32;
    localparam int REG_AW    = 5;
    localparam int REG_COUNT = 32;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_LW      = 6'h23;

    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;

    localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
    localparam logic [REG_AW-1:0] REG_V0   = 5'd2;
    localparam logic [REG_AW-1:0] REG_A0   = 5'd4;

    localparam logic [WORD_W-1:0] SYS_PRINT_INT = 32'd1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [PC_BITS-1:0] pc_t;

endpackage

FILE: design/mips_subset_instruction_execute.sv
// Top level of the single-issue instruction execute block.
// Holds the register file, data RAM, program counter and result register.
// Depends on msie_pkg.
`timescale 1ns / 1ps

// One instruction is accepted per clock cycle while in_stall is low. An accepted
// instruction sits in the input register, where its operands are read and it
// executes, and its result is registered into the result register as it leaves.
// While a result waits under out_stall, the next instruction holds in the input
// register, and the input stalls once both are occupied. Register results are
// registered for write-back after execution and forwarded to the following
// instruction, so dependent instructions run back to back without stalls. After
// reset the data RAM is cleared one word per cycle, and no instruction is accepted
// until it finishes. The program length register may be written at any time the
// block is idle.
module mips_subset_instruction_execute (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [msie_pkg::WORD_W-1:0]        instruction_word,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [msie_pkg::OUT_PC_W-1:0]      next_pc,
    output logic                               halted,
    output logic                               print_valid,
    output logic signed [msie_pkg::WORD_W-1:0] print_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [msie_pkg::LEN_W-1:0]         program_length
);
    import msie_pkg::*;

    word_t                rf_mem [REG_COUNT];
    word_t                ram_mem [RAM_WORDS];

    logic [REG_COUNT-1:0] rf_valid_reg, rf_valid_next;
    logic                 clr_active_reg, clr_active_next;
    logic [RAM_AW-1:0]    clr_idx_reg, clr_idx_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    pc_t                  pc_reg, pc_next;

    logic                 s1_valid_reg, s1_valid_next;
    word_t                s1_instr_reg;
    word_t                rf_qa_reg, rf_qb_reg;
    logic                 rf_va_reg, rf_va_next;
    logic                 rf_vb_reg, rf_vb_next;
    logic                 ovr_a_reg, ovr_a_next;
    logic                 ovr_b_reg, ovr_b_next;
    word_t                ovr_a_data_reg, ovr_a_data_next;
    word_t                ovr_b_data_reg, ovr_b_data_next;
    word_t                v0_reg, v0_next;
    word_t                a0_reg, a0_next;

    logic                 wb_we_reg, wb_we_next;
    logic [REG_AW-1:0]    wb_addr_reg;
    word_t                wb_alu_reg;
    logic                 wb_load_reg;
    word_t                ram_q_reg;
    word_t                wb_data;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_PC_W-1:0]  next_pc_reg;
    logic                 halted_reg;
    logic                 print_valid_reg;
    word_t                print_value_reg;

    logic                 in_fire;
    logic                 s1_fire;
    logic [REG_AW-1:0]    in_rs, in_rt;

    logic [5:0]           ex_op, ex_funct;
    logic [REG_AW-1:0]    ex_rs, ex_rt, ex_rd;
    logic [15:0]          ex_imm;
    word_t                ex_imm_sext, ex_imm_zext;
    word_t                op_a, op_b, op_v0, op_a0;
    word_t                ex_addr;
    logic [RAM_AW-1:0]    ex_ram_idx;
    logic                 ex_halt;
    pc_t                  ex_pc_inc, ex_target, ex_next_pc;
    logic                 ex_wr_en;
    logic [REG_AW-1:0]    ex_wr_addr;
    word_t                ex_alu;
    logic                 ex_load, ex_store;
    logic                 ex_pv;
    word_t                ex_pval;

    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    word_t                ram_wdata;

    assign in_fire   = in_valid && !in_stall;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = clr_active_reg || (s1_valid_reg && !s1_fire);
    assign cfg_ready = 1'b1;
    assign in_rs     = instruction_word[25:21];
    assign in_rt     = instruction_word[20:16];
    assign wb_data   = wb_load_reg ? ram_q_reg : wb_alu_reg;

    assign ex_op       = s1_instr_reg[31:26];
    assign ex_rs       = s1_instr_reg[25:21];
    assign ex_rt       = s1_instr_reg[20:16];
    assign ex_rd       = s1_instr_reg[15:11];
    assign ex_funct    = s1_instr_reg[5:0];
    assign ex_imm      = s1_instr_reg[15:0];
    assign ex_imm_sext = {{(WORD_W - 16){ex_imm[15]}}, ex_imm};
    assign ex_imm_zext = {{(WORD_W - 16){1'b0}}, ex_imm};

    // Operands take the value being written back this cycle first, then a value
    // caught while the instruction waited, then the registered file read.
    always_comb
    begin
        if (wb_we_reg && (wb_addr_reg == ex_rs))
            op_a = wb_data;
        else if (ovr_a_reg)
            op_a = ovr_a_data_reg;
        else
            op_a = rf_va_reg ? rf_qa_reg : '0;

        if (wb_we_reg && (wb_addr_reg == ex_rt))
            op_b = wb_data;
        else if (ovr_b_reg)
            op_b = ovr_b_data_reg;
        else
            op_b = rf_vb_reg ? rf_qb_reg : '0;

        op_v0 = (wb_we_reg && (wb_addr_reg == REG_V0)) ? wb_data : v0_reg;
        op_a0 = (wb_we_reg && (wb_addr_reg == REG_A0)) ? wb_data : a0_reg;
    end

    assign ex_addr    = op_a + ex_imm_sext;
    assign ex_ram_idx = ex_addr[RAM_AW+1:2];
    assign ex_halt    = WORD_W'(pc_reg) >= WORD_W'(len_reg);
    assign ex_pc_inc  = pc_reg + PC_BITS'(1);
    assign ex_target  = ex_pc_inc + ex_imm_sext[PC_BITS-1:0];

    always_comb
    begin
        ex_wr_en   = 1'b0;
        ex_wr_addr = ex_rt;
        ex_alu     = '0;
        ex_load    = 1'b0;
        ex_store   = 1'b0;
        ex_pv      = 1'b0;
        ex_pval    = '0;
        ex_next_pc = ex_pc_inc;

        unique case (ex_op)
            OP_SPECIAL:
            begin
                ex_wr_addr = ex_rd;
                unique case (ex_funct) inside
                    FN_ADD, FN_ADDU:
                    begin
                        ex_wr_en = 1'b1;
                        ex_alu   = op_a + op_b;
                    end
                    FN_SUB:
                    begin
                        ex_wr_en = 1'b1;
                        ex_alu   = op_a - op_b;
                    end
                    FN_OR:
                    begin
                        ex_wr_en = 1'b1;
                        ex_alu   = op_a | op_b;
                    end
                    FN_SYSCALL:
                    begin
                        if (op_v0 == SYS_PRINT_INT)
                        begin
                            ex_pv   = 1'b1;
                            ex_pval = op_a0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_BNE:
            begin
                if (op_a != op_b)
                    ex_next_pc = ex_target;
            end
            OP_ADDI:
            begin
                ex_wr_en = 1'b1;
                ex_alu   = op_a + ex_imm_sext;
            end
            OP_ORI:
            begin
                ex_wr_en = 1'b1;
                ex_alu   = op_a | ex_imm_zext;
            end
            OP_SW:
            begin
                ex_store = 1'b1;
            end
            OP_LW:
            begin
                ex_wr_en = 1'b1;
                ex_load  = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (ex_wr_addr == REG_ZERO)
            ex_wr_en = 1'b0;

        if (ex_halt)
        begin
            ex_wr_en   = 1'b0;
            ex_load    = 1'b0;
            ex_store   = 1'b0;
            ex_pv      = 1'b0;
            ex_pval    = '0;
            ex_next_pc = pc_reg;
        end
    end

    assign ram_we    = clr_active_reg || (s1_fire && ex_store);
    assign ram_waddr = clr_active_reg ? clr_idx_reg : ex_ram_idx;
    assign ram_wdata = clr_active_reg ? '0 : op_b;

    always_ff @(posedge clk)
    begin
        if (ram_we)
            ram_mem[ram_waddr] <= ram_wdata;
        if (s1_fire && ex_load)
            ram_q_reg <= ram_mem[ex_ram_idx];
    end

    always_ff @(posedge clk)
    begin
        if (wb_we_reg)
            rf_mem[wb_addr_reg] <= wb_data;
        if (in_fire)
        begin
            rf_qa_reg <= rf_mem[in_rs];
            rf_qb_reg <= rf_mem[in_rt];
        end
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + RAM_AW'(1);
            if (clr_idx_reg == RAM_AW'(RAM_WORDS - 1))
                clr_active_next = 1'b0;
        end

        len_next = cfg_valid ? program_length : len_reg;
        pc_next  = s1_fire ? ex_next_pc : pc_reg;

        rf_valid_next = rf_valid_reg;
        v0_next       = v0_reg;
        a0_next       = a0_reg;
        if (wb_we_reg)
        begin
            rf_valid_next[wb_addr_reg] = 1'b1;
            if (wb_addr_reg == REG_V0)
                v0_next = wb_data;
            if (wb_addr_reg == REG_A0)
                a0_next = wb_data;
        end

        s1_valid_next   = s1_valid_reg;
        rf_va_next      = rf_va_reg;
        rf_vb_next      = rf_vb_reg;
        ovr_a_next      = ovr_a_reg;
        ovr_b_next      = ovr_b_reg;
        ovr_a_data_next = ovr_a_data_reg;
        ovr_b_data_next = ovr_b_data_reg;
        if (in_fire)
        begin
            s1_valid_next   = 1'b1;
            rf_va_next      = rf_valid_reg[in_rs];
            rf_vb_next      = rf_valid_reg[in_rt];
            ovr_a_next      = wb_we_reg && (wb_addr_reg == in_rs);
            ovr_b_next      = wb_we_reg && (wb_addr_reg == in_rt);
            ovr_a_data_next = wb_data;
            ovr_b_data_next = wb_data;
        end
        else
        begin
            if (s1_fire)
                s1_valid_next = 1'b0;
            if (wb_we_reg && (wb_addr_reg == ex_rs))
            begin
                ovr_a_next      = 1'b1;
                ovr_a_data_next = wb_data;
            end
            if (wb_we_reg && (wb_addr_reg == ex_rt))
            begin
                ovr_b_next      = 1'b1;
                ovr_b_data_next = wb_data;
            end
        end

        wb_we_next     = s1_fire && ex_wr_en;
        out_valid_next = s1_fire || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            len_reg        <= LEN_W'(1);
            pc_reg         <= '0;
            rf_valid_reg   <= '0;
            v0_reg         <= '0;
            a0_reg         <= '0;
            s1_valid_reg   <= 1'b0;
            rf_va_reg      <= 1'b0;
            rf_vb_reg      <= 1'b0;
            ovr_a_reg      <= 1'b0;
            ovr_b_reg      <= 1'b0;
            wb_we_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            len_reg        <= len_next;
            pc_reg         <= pc_next;
            rf_valid_reg   <= rf_valid_next;
            v0_reg         <= v0_next;
            a0_reg         <= a0_next;
            s1_valid_reg   <= s1_valid_next;
            rf_va_reg      <= rf_va_next;
            rf_vb_reg      <= rf_vb_next;
            ovr_a_reg      <= ovr_a_next;
            ovr_b_reg      <= ovr_b_next;
            wb_we_reg      <= wb_we_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovr_a_data_reg <= ovr_a_data_next;
        ovr_b_data_reg <= ovr_b_data_next;
        if (in_fire)
            s1_instr_reg <= instruction_word;
        if (s1_fire)
        begin
            wb_addr_reg     <= ex_wr_addr;
            wb_alu_reg      <= ex_alu;
            wb_load_reg     <= ex_load;
            next_pc_reg     <= OUT_PC_W'(ex_next_pc);
            halted_reg      <= WORD_W'(ex_next_pc) >= WORD_W'(len_reg);
            print_valid_reg <= ex_pv;
            print_value_reg <= ex_pval;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = next_pc_reg;
    assign halted      = halted_reg;
    assign print_valid = print_valid_reg;
    assign print_value = print_value_reg;

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("Executed transaction did not reach the result register.");

    a_writeback_follows_fire: assert property (@(posedge clk) disable iff (!rst_n)
        wb_we_reg |-> $past(s1_fire))
        else $error("Register write-back without a preceding execution.");

    a_zero_never_written: assert property (@(posedge clk) disable iff (!rst_n)
        wb_we_reg |-> (wb_addr_reg != REG_ZERO))
        else $error("Write-back targets register zero.");

    a_no_exec_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_valid_reg && !wb_we_reg)
        else $error("Instruction in flight during the RAM clearing pass.");

    a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && ex_halt) |=> (pc_reg == $past(pc_reg)) && halted_reg)
        else $error("Program counter moved while halted.");

endmodule
